// ----- design/pixel_sample_resolve_gamma_pack_core_macros.svh -----
// assertion helpers shared by the resolve core
`ifndef PIXEL_SAMPLE_RESOLVE_GAMMA_PACK_CORE_MACROS_SVH
`define PIXEL_SAMPLE_RESOLVE_GAMMA_PACK_CORE_MACROS_SVH

`ifndef SYNTH
`define PSRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psrg same-cycle check failed");
`define PSRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psrg next-cycle check failed");
`else
`define PSRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/psrg_pkg.sv -----
package psrg_pkg;

    localparam int NUM_CH     = 3;
    localparam int SUM_W      = 28;
    localparam int CNT_W      = 13;
    localparam int CH_W       = 8;
    localparam int PIX_W      = NUM_CH * CH_W;
    localparam int SQ_IN_W    = 2 * CH_W;
    localparam int SQ_REM_W   = CH_W + 2;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = ADDR_W - 2;

    // iterations folded into one register stage
    localparam int DIV_STEPS  = 2;
    localparam int SQ_STEPS   = 2;
    localparam int DIV_STAGES = SUM_W / DIV_STEPS;
    localparam int SQ_STAGES  = CH_W / SQ_STEPS;

    localparam int CH_RED     = 0;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 2;

    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = '0;

    typedef logic [NUM_CH-1:0][SUM_W-1:0]    sum3_t;
    typedef logic [NUM_CH-1:0][CNT_W-1:0]    rem3_t;
    typedef logic [NUM_CH-1:0][SQ_IN_W-1:0]  sqin3_t;
    typedef logic [NUM_CH-1:0][SQ_REM_W-1:0] sqrem3_t;
    typedef logic [NUM_CH-1:0][CH_W-1:0]     root3_t;

endpackage

// ----- design/pixel_sample_resolve_gamma_pack_core.sv -----
// an accepted input beat passes through the divider stages and then the square-root stages to its result beat
// throughput: one pixel per cycle while m_ready is high; 14 divider stages and 4 square-root stages, 2 bits each
// each stage holds while full and blocked, so bubbles close up behind a stalled output
// reset: synchronous active-low aresetn empties the pipeline and sets sample_count to 1
`include "pixel_sample_resolve_gamma_pack_core_macros.svh"

module pixel_sample_resolve_gamma_pack_core
    import psrg_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int FRAC_BITS   = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SUM_W-1:0]  s_red_sum,
    input  logic [SUM_W-1:0]  s_green_sum,
    input  logic [SUM_W-1:0]  s_blue_sum,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PIX_W-1:0]  m_packed_pixel
);

    localparam logic [CNT_W-1:0] CNT_CAP =
        (MAX_SAMPLES >= (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(MAX_SAMPLES);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] eff_count_reg;
    logic [CNT_W-1:0] eff_count_next;
    logic             cfg_hit;
    sum3_t            in_sum;
    logic             mid_valid;
    logic             mid_ready;
    sum3_t            mid_quot;

    assign pready  = 1'b1;
    assign cfg_hit = psel && penable && pwrite && pready &&
                     (paddr[ADDR_W-1:2] == REG_SAMPLE_COUNT);
    assign prdata  = (paddr[ADDR_W-1:2] == REG_SAMPLE_COUNT) ?
                     {{(DATA_W-CNT_W){1'b0}}, count_reg} : '0;

    // divisor is cleaned up once at write time: zero acts as one, large counts cap
    always_comb begin
        count_next = pwdata[CNT_W-1:0];
        priority if (count_next == '0) begin
            eff_count_next = CNT_W'(1);
        end else if (count_next > CNT_CAP) begin
            eff_count_next = CNT_CAP;
        end else begin
            eff_count_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= CNT_W'(1);
            eff_count_reg <= CNT_W'(1);
        end else if (cfg_hit) begin
            count_reg     <= count_next;
            eff_count_reg <= eff_count_next;
        end
    end

    always_comb begin
        in_sum         = '0;
        in_sum[CH_RED]   = s_red_sum;
        in_sum[CH_GREEN] = s_green_sum;
        in_sum[CH_BLUE]  = s_blue_sum;
    end

    psrg_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_count  (eff_count_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sum    (in_sum),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_quot  (mid_quot)
    );

    psrg_sqrt_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_quot   (mid_quot),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pixel (m_packed_pixel)
    );

    `PSRG_ASSERT_IMP(a_cnt_nonzero, aclk, aresetn, 1'b1, eff_count_reg != '0)
    `PSRG_ASSERT_IMP(a_cnt_capped, aclk, aresetn, 1'b1, eff_count_reg <= CNT_CAP)

endmodule

// ----- design/psrg_div_pipe.sv -----
`include "pixel_sample_resolve_gamma_pack_core_macros.svh"

module psrg_div_pipe
    import psrg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] in_count,
    input  logic             in_valid,
    output logic             in_ready,
    input  sum3_t            in_sum,
    output logic             out_valid,
    input  logic             out_ready,
    output sum3_t            out_quot
);

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] stage_ready;
    sum3_t                 work_reg [DIV_STAGES];
    rem3_t                 rem_reg  [DIV_STAGES];

    // restoring long division: dividend bits leave the top of work, quotient bits enter below
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic  up_valid;
        sum3_t up_work;
        rem3_t up_rem;
        sum3_t work_next;
        rem3_t rem_next;

        if (k == 0) begin : g_first
            assign up_valid = in_valid;
            assign up_work  = in_sum;
            assign up_rem   = '0;
        end else begin : g_rest
            assign up_valid = valid_reg[k-1];
            assign up_work  = work_reg[k-1];
            assign up_rem   = rem_reg[k-1];
        end

        if (k == DIV_STAGES - 1) begin : g_tail
            assign stage_ready[k] = ~valid_reg[k] | out_ready;
        end else begin : g_mid
            assign stage_ready[k] = ~valid_reg[k] | stage_ready[k+1];
        end

        always_comb begin
            logic [CNT_W:0] trial;
            logic           qbit;
            work_next = up_work;
            rem_next  = up_rem;
            for (int c = 0; c < NUM_CH; c++) begin
                for (int s = 0; s < DIV_STEPS; s++) begin
                    trial = {rem_next[c], work_next[c][SUM_W-1]};
                    qbit  = (trial >= {1'b0, in_count});
                    if (qbit) begin
                        trial = trial - {1'b0, in_count};
                    end
                    rem_next[c]  = trial[CNT_W-1:0];
                    work_next[c] = {work_next[c][SUM_W-2:0], qbit};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (stage_ready[k]) begin
                valid_reg[k] <= up_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[k] && up_valid) begin
                work_reg[k] <= work_next;
                rem_reg[k]  <= rem_next;
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quot  = work_reg[DIV_STAGES-1];

    `PSRG_ASSERT_NXT(a_div_hold, aclk, aresetn, out_valid && !out_ready, out_valid && $stable(out_quot))
    `PSRG_ASSERT_IMP(a_div_rdy, aclk, aresetn, !out_valid, in_ready)

endmodule

// ----- design/psrg_sqrt_pipe.sv -----
`include "pixel_sample_resolve_gamma_pack_core_macros.svh"

module psrg_sqrt_pipe
    import psrg_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sum3_t            in_quot,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel
);

    localparam int UP_SH   = (FRAC_BITS <= SQ_IN_W) ? SQ_IN_W - FRAC_BITS : 0;
    localparam int DOWN_SH = (FRAC_BITS > SQ_IN_W) ? FRAC_BITS - SQ_IN_W : 0;
    localparam logic [SUM_W-1:0] MEAN_MAX = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

    logic [SQ_STAGES-1:0] valid_reg;
    logic [SQ_STAGES-1:0] stage_ready;
    sqin3_t               vin_reg  [SQ_STAGES];
    sqrem3_t              srem_reg [SQ_STAGES];
    root3_t               root_reg [SQ_STAGES];
    sqin3_t               scaled;

    // saturate the mean just under one, then line it up as 16 fraction bits
    always_comb begin
        logic [SUM_W-1:0] mean;
        for (int c = 0; c < NUM_CH; c++) begin
            mean      = (in_quot[c] > MEAN_MAX) ? MEAN_MAX : in_quot[c];
            scaled[c] = SQ_IN_W'((mean << UP_SH) >> DOWN_SH);
        end
    end

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic    up_valid;
        sqin3_t  up_v;
        sqrem3_t up_rem;
        root3_t  up_root;
        sqin3_t  v_next;
        sqrem3_t rem_next;
        root3_t  root_next;

        if (k == 0) begin : g_first
            assign up_valid = in_valid;
            assign up_v     = scaled;
            assign up_rem   = '0;
            assign up_root  = '0;
        end else begin : g_rest
            assign up_valid = valid_reg[k-1];
            assign up_v     = vin_reg[k-1];
            assign up_rem   = srem_reg[k-1];
            assign up_root  = root_reg[k-1];
        end

        if (k == SQ_STAGES - 1) begin : g_tail
            assign stage_ready[k] = ~valid_reg[k] | out_ready;
        end else begin : g_mid
            assign stage_ready[k] = ~valid_reg[k] | stage_ready[k+1];
        end

        // one root bit per step, two radicand bits consumed
        always_comb begin
            logic [SQ_REM_W+1:0] trial;
            logic [SQ_REM_W+1:0] sub;
            logic                rbit;
            v_next    = up_v;
            rem_next  = up_rem;
            root_next = up_root;
            for (int c = 0; c < NUM_CH; c++) begin
                for (int s = 0; s < SQ_STEPS; s++) begin
                    trial = {rem_next[c], v_next[c][SQ_IN_W-1 -: 2]};
                    sub   = {2'b00, root_next[c], 2'b01};
                    rbit  = (trial >= sub);
                    if (rbit) begin
                        trial = trial - sub;
                    end
                    rem_next[c]  = trial[SQ_REM_W-1:0];
                    root_next[c] = {root_next[c][CH_W-2:0], rbit};
                    v_next[c]    = {v_next[c][SQ_IN_W-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (stage_ready[k]) begin
                valid_reg[k] <= up_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[k] && up_valid) begin
                vin_reg[k]  <= v_next;
                srem_reg[k] <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[SQ_STAGES-1];
    assign out_pixel = {root_reg[SQ_STAGES-1][CH_RED],
                        root_reg[SQ_STAGES-1][CH_GREEN],
                        root_reg[SQ_STAGES-1][CH_BLUE]};

    logic [SQ_REM_W-1:0] twice_red_root;
    assign twice_red_root = {1'b0, root_reg[SQ_STAGES-1][CH_RED], 1'b0};

    // remainder of an exact floor root never exceeds twice the root
    `PSRG_ASSERT_IMP(a_sq_rem, aclk, aresetn, out_valid, srem_reg[SQ_STAGES-1][CH_RED] <= twice_red_root)

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psrg_pkg::*;

    localparam int MAX_SAMPLES = 4096;
    localparam int FRAC_BITS   = 16;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_IDX_W'(1);
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 200;
    localparam int REPORT_LIMIT = 10;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic [SUM_W-1:0]  s_red_sum;
    logic [SUM_W-1:0]  s_green_sum;
    logic [SUM_W-1:0]  s_blue_sum;
    logic              m_valid;
    logic              m_ready;
    logic [PIX_W-1:0]  m_packed_pixel;

    // local copy of the count register and the pixels still owed by the block
    logic [CNT_W-1:0]  cfg_sample_count = CNT_W'(1);
    logic [PIX_W-1:0]  expected_pixels[$];

    int  fail_count    = 0;
    int  pixels_sent   = 0;
    int  pixels_seen   = 0;
    int  settings_used = 0;
    bit  src_idle_en   = 1'b1;
    bit  sink_idle_en  = 1'b1;
    int  hold_request  = 0;

    always #2 aclk = ~aclk;

    pixel_sample_resolve_gamma_pack_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red_sum      (s_red_sum),
        .s_green_sum    (s_green_sum),
        .s_blue_sum     (s_blue_sum),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packed_pixel (m_packed_pixel)
    );

    function automatic int unsigned sample_divisor(input logic [CNT_W-1:0] cnt);
        if (cnt == 0) return 1;
        if (cnt > MAX_SAMPLES) return MAX_SAMPLES;
        return cnt;
    endfunction

    // floor(256 * sqrt(mean)) with the mean held below one
    function automatic logic [CH_W-1:0] gamma_level(input logic [SUM_W-1:0] sum,
                                                    input int unsigned div);
        longint unsigned mean;
        longint unsigned scaled;
        longint unsigned root;
        longint unsigned trial;
        mean = 64'(sum) / div;
        if (mean > (64'd1 << FRAC_BITS) - 1) mean = (64'd1 << FRAC_BITS) - 1;
        if (FRAC_BITS <= 16) scaled = mean << (16 - FRAC_BITS);
        else scaled = mean >> (FRAC_BITS - 16);
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= scaled) root = trial;
        end
        if (root > 255) root = 255;
        return root[CH_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] resolve_pixel(input logic [SUM_W-1:0] r,
                                                       input logic [SUM_W-1:0] g,
                                                       input logic [SUM_W-1:0] b);
        int unsigned div;
        div = sample_divisor(cfg_sample_count);
        return {gamma_level(r, div), gamma_level(g, div), gamma_level(b, div)};
    endfunction

    // mostly sums whose mean lands in range, some near saturation, some raw
    function automatic logic [SUM_W-1:0] rand_sum(input int unsigned div);
        longint unsigned mean;
        longint unsigned sum;
        case ($urandom_range(0, 4))
            0: return SUM_W'($urandom);
            1: mean = $urandom_range(64000, 67000);
            2: mean = $urandom_range(0, 300);
            default: mean = $urandom_range(0, 65535);
        endcase
        sum = mean * div + $urandom_range(0, div - 1);
        if (sum > SUM_MAX) sum = SUM_MAX;
        return sum[SUM_W-1:0];
    endfunction

    task automatic note_failure(input string what, input logic [PIX_W-1:0] want,
                                input logic [PIX_W-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%t: %s: expected %06h got %06h", $realtime, what, want, got);
    endtask

    // input beats: predict at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_pixels.push_back(resolve_pixel(s_red_sum, s_green_sum, s_blue_sum));
            pixels_sent++;
        end
    end

    // output beats: compare with the oldest prediction
    always @(posedge aclk) begin
        logic [PIX_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                note_failure("unexpected pixel", '0, m_packed_pixel);
            end else begin
                want = expected_pixels.pop_front();
                if (m_packed_pixel !== want) note_failure("pixel mismatch", want, m_packed_pixel);
            end
        end
    end

    // receiver: random stalls, and a long hold when asked
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
                m_ready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [SUM_W-1:0] r, input logic [SUM_W-1:0] g,
                              input logic [SUM_W-1:0] b);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_red_sum   <= r;
        s_green_sum <= g;
        s_blue_sum  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random(input int n);
        int unsigned div;
        div = sample_divisor(cfg_sample_count);
        repeat (n) send_pixel(rand_sum(div), rand_sum(div), rand_sum(div));
    endtask

    // drop valid and wait until every owed pixel is back
    task automatic finish_phase();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SAMPLE_COUNT) cfg_sample_count = data[CNT_W-1:0];
        // leave the bus idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic check_sample_count();
        logic [DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_SAMPLE_COUNT, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== DATA_W'(cfg_sample_count))
            note_failure("sample_count readback", PIX_W'(cfg_sample_count), PIX_W'(got));
        @(posedge aclk);
    endtask

    // upper bus bits are junk, only the low count bits land
    task automatic set_sample_count(input logic [CNT_W-1:0] cnt);
        logic [DATA_W-1:0] data;
        data = $urandom;
        data[CNT_W-1:0] = cnt;
        apb_write(REG_SAMPLE_COUNT, data);
        check_sample_count();
        settings_used++;
    endtask

    task automatic test_register_access();
        check_sample_count();
        apb_write(REG_UNMAPPED, 32'd5);
        check_sample_count();
        send_pixel(28'd65535, 28'd0, 28'd256);
        send_pixel(28'd1, 28'd4, 28'd65536);
        finish_phase();
    endtask

    task automatic test_value_extremes();
        set_sample_count(CNT_W'(1));
        send_pixel('0, '0, '0);
        send_pixel(SUM_MAX, SUM_MAX, SUM_MAX);
        // square boundaries around 255 and the saturation point
        send_pixel(28'd65025, 28'd65024, 28'd65535);
        send_pixel(28'd65536, 28'd255, 28'd256);
        send_pixel(28'hAAAAAAA, 28'h5555555, 28'h000FFFF);
        send_pixel(28'h5555555, 28'hAAAAAAA, 28'h0010000);
        send_pixel(28'd3, 28'd15, 28'd16);
        send_pixel(28'd1, 28'd0, SUM_MAX);
        finish_phase();
    endtask

    task automatic test_count_limits();
        // zero count acts as one
        set_sample_count(CNT_W'(0));
        send_pixel(28'd65535, 28'd0, 28'd1);
        send_pixel(28'd131072, 28'd4, 28'd65024);
        finish_phase();
        // counts above the maximum saturate
        set_sample_count(CNT_W'(4097));
        send_pixel(28'(4096 * 65535), 28'(4096 * 65025 - 1), 28'(4096 * 256));
        send_pixel(SUM_MAX, 28'd4095, 28'd4096);
        finish_phase();
        set_sample_count('1);
        send_pixel(28'(4096 * 100), 28'(4096 * 65024), SUM_MAX);
        finish_phase();
        set_sample_count(CNT_W'(MAX_SAMPLES));
        send_pixel(28'(4096 * 65535), 28'(4096 * 65535 - 1), 28'(4096 * 16));
        finish_phase();
        // quotient truncates
        set_sample_count(CNT_W'(3));
        send_pixel(28'(3 * 256 + 2), 28'(3 * 256 - 1), 28'd2);
        finish_phase();
    endtask

    task automatic test_output_stall();
        set_sample_count(CNT_W'($urandom_range(1, 16)));
        hold_request = LONG_HOLD;
        send_random(60);
        finish_phase();
    endtask

    task automatic test_random_settings();
        logic [CNT_W-1:0] counts[7];
        counts = '{CNT_W'(1), CNT_W'(2), CNT_W'(MAX_SAMPLES), '1, '0,
                   CNT_W'($urandom_range(3, 64)), CNT_W'($urandom)};
        foreach (counts[i]) begin
            set_sample_count(counts[i]);
            send_random(100);
            finish_phase();
        end
    endtask

    task automatic test_full_rate();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        set_sample_count(CNT_W'($urandom_range(1, 300)));
        send_random(100);
        finish_phase();
    endtask

    initial begin
        aresetn     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_valid     <= 1'b0;
        s_red_sum   <= '0;
        s_green_sum <= '0;
        s_blue_sum  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_access();
        test_value_extremes();
        test_count_limits();
        test_output_stall();
        test_random_settings();
        test_full_rate();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_pixels.size() != 0) begin
            fail_count++;
            $display("%0d pixels never came out", expected_pixels.size());
        end
        $display("resolved %0d of %0d pixels across %0d sample-count writes,",
                 pixels_seen, pixels_sent, settings_used);
        $display("with random stalls on both sides and one long output hold");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for the block");
        $display("Test completed with failures");
        $finish;
    end

endmodule
